// ===== rtl/ppfa_pkg.sv =====
// ----------------------------------------------------------------------------
// ppfa_pkg
// Shared types, codes and helpers of the physical page frame allocator.
// ----------------------------------------------------------------------------
package ppfa_pkg;

    localparam int unsigned ADDR_W = 64;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam logic [ADDR_W-1:0] LOW_MEM_END = 64'h0000_0000_0010_0000;

    // Item actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_PAGE   = 2'd1;
    localparam logic [1:0] ST_HIST_FULL = 2'd2;
    localparam logic [1:0] ST_MAP_FULL  = 2'd3;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_KERNEL_START = 3'd0;
    localparam logic [2:0] REG_KERNEL_END   = 3'd1;
    localparam logic [2:0] REG_STACK_START  = 3'd2;
    localparam logic [2:0] REG_STACK_END    = 3'd3;
    localparam logic [2:0] REG_BI_BASE      = 3'd4;
    localparam logic [2:0] REG_BI_BYTES     = 3'd5;

    // Result of the shared arithmetic unit
    typedef struct packed {
        logic [ADDR_W:0] sum;  // a + b with carry out
        logic            lt;   // a < b, unsigned
    } t_alu_res;

    // Page round-up with overflow flag
    typedef struct packed {
        logic            ovf;
        logic [ADDR_W-1:0] val;
    } t_rnd;

    function automatic t_rnd round_page(input logic [ADDR_W-1:0] v);
        t_rnd r;
        logic up;
        up = (v[PAGE_SHIFT-1:0] != '0);
        r.ovf = up && (&v[ADDR_W-1:PAGE_SHIFT]);
        r.val = {v[ADDR_W-1:PAGE_SHIFT] + {{(ADDR_W-PAGE_SHIFT-1){1'b0}}, up},
                 {PAGE_SHIFT{1'b0}}};
        return r;
    endfunction

    // Next page address (argument is page aligned)
    function automatic logic [ADDR_W-1:0] next_page(input logic [ADDR_W-1:0] p);
        return {p[ADDR_W-1:PAGE_SHIFT] + {{(ADDR_W-PAGE_SHIFT-1){1'b0}}, 1'b1},
                {PAGE_SHIFT{1'b0}}};
    endfunction

endpackage

// ===== rtl/ppfa_ram.sv =====
// ----------------------------------------------------------------------------
// ppfa_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ppfa_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ppfa_alu.sv =====
// ----------------------------------------------------------------------------
// ppfa_alu
// Shared 64-bit add and unsigned compare unit used by the sequencer.
// ----------------------------------------------------------------------------
module ppfa_alu (
    input  logic [ppfa_pkg::ADDR_W-1:0] i_a,
    input  logic [ppfa_pkg::ADDR_W-1:0] i_b,
    output ppfa_pkg::t_alu_res          o_res
);

    // Add with carry and compare
    always_comb begin
        o_res.sum = {1'b0, i_a} + {1'b0, i_b};
        o_res.lt  = (i_a < i_b);
    end

endmodule

// ===== rtl/physical_page_frame_allocator_top.sv =====
// ----------------------------------------------------------------------------
// physical_page_frame_allocator_top
// Bump allocator of 4 KiB physical pages over a loaded memory map.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// input     in         i_valid / o_ready, i_action, i_entry_addr, i_entry_len,
//                      i_entry_type
// result    out        o_valid / i_ready, o_page_addr, o_status
// config    in         psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A load item goes from idle straight to the done state. An allocate item
// walks candidate pages one at a time: each page passes the range checks
// (S_FTOP, S_HIT1, S_HIT2), then one history RAM read and compare per history
// entry (S_HRD, S_HCMP) and a last S_HRD to finish, and each map entry takes
// a map RAM read and check (S_RRD, S_RCHK).
// The block takes one item at a time; o_ready is high only when idle.
// A finished result waits in the output register while the next item enters.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module physical_page_frame_allocator_top #(
    parameter int unsigned MAP_DEPTH     = 16,
    parameter int unsigned HISTORY_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [63:0] i_entry_addr,
    input  logic [63:0] i_entry_len,
    input  logic [31:0] i_entry_type,
    // result items
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_page_addr,
    output logic [1:0]  o_status,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int unsigned MAW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int unsigned MCW = $clog2(MAP_DEPTH + 1);
    localparam int unsigned HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned HCW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned AW  = ppfa_pkg::ADDR_W;
    localparam int unsigned PS  = ppfa_pkg::PAGE_SHIFT;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ALLOC = 4'd1;
    localparam logic [3:0] S_CUR   = 4'd2;
    localparam logic [3:0] S_FTOP  = 4'd3;
    localparam logic [3:0] S_HIT1  = 4'd4;
    localparam logic [3:0] S_HIT2  = 4'd5;
    localparam logic [3:0] S_HRD   = 4'd6;
    localparam logic [3:0] S_HCMP  = 4'd7;
    localparam logic [3:0] S_RRD   = 4'd8;
    localparam logic [3:0] S_RCHK  = 4'd9;
    localparam logic [3:0] S_REC   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // Configuration registers
    logic [63:0] r_kstart, r_kend, r_sstart, r_send;
    logic [31:0] r_bi_base;
    logic [20:0] r_bi_bytes;
    logic [63:0] bi_end;

    // Sequencer registers
    logic [3:0]     r_state;
    logic [MCW-1:0] r_map_cnt;
    logic [HCW-1:0] r_hist_cnt;
    logic [MCW-1:0] r_ridx;
    logic [HCW-1:0] r_hidx;
    logic [1:0]     r_rng;
    logic           r_mode;   // 0 cursor continue, 1 region rescan
    logic [AW-1:0]  r_p, r_end, r_cursor, r_limit;
    logic [AW-1:0]  r_res_page;
    logic [1:0]     r_res_status;
    logic           r_out_valid;
    logic [AW-1:0]  r_out_page;
    logic [1:0]     r_out_status;

    // Memories
    logic              map_we, hist_we;
    logic [2*AW:0]     map_rdata;
    logic [AW-1:0]     hist_rdata;
    logic [AW-1:0]     map_base, map_len;
    logic              map_usable;

    // Shared unit
    logic [AW-1:0]       alu_a, alu_b;
    ppfa_pkg::t_alu_res  alu_res;
    logic [AW-1:0]       rng_s, rng_e, p_inc;
    ppfa_pkg::t_rnd      rnd_e, rnd_b;
    logic                in_acc, cfg_wr;

    assign in_acc = i_valid && o_ready;
    assign cfg_wr = psel && penable && pwrite;
    assign bi_end = {32'd0, r_bi_base} + {43'd0, r_bi_bytes};
    assign pready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kstart   <= '0;
            r_kend     <= '0;
            r_sstart   <= '0;
            r_send     <= '0;
            r_bi_base  <= '0;
            r_bi_bytes <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                ppfa_pkg::REG_KERNEL_START: r_kstart   <= pwdata;
                ppfa_pkg::REG_KERNEL_END:   r_kend     <= pwdata;
                ppfa_pkg::REG_STACK_START:  r_sstart   <= pwdata;
                ppfa_pkg::REG_STACK_END:    r_send     <= pwdata;
                ppfa_pkg::REG_BI_BASE:      r_bi_base  <= pwdata[31:0];
                ppfa_pkg::REG_BI_BYTES:     r_bi_bytes <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        unique case (paddr[5:3])
            ppfa_pkg::REG_KERNEL_START: prdata = r_kstart;
            ppfa_pkg::REG_KERNEL_END:   prdata = r_kend;
            ppfa_pkg::REG_STACK_START:  prdata = r_sstart;
            ppfa_pkg::REG_STACK_END:    prdata = r_send;
            ppfa_pkg::REG_BI_BASE:      prdata = {32'd0, r_bi_base};
            ppfa_pkg::REG_BI_BYTES:     prdata = {43'd0, r_bi_bytes};
            default:                    prdata = '0;
        endcase
    end

    // Map table: base, length, usable flag
    assign map_we = in_acc && (i_action == ppfa_pkg::ACT_LOAD) &&
                    (r_map_cnt < MCW'(MAP_DEPTH));

    ppfa_ram #(.WIDTH(2*AW+1), .DEPTH(MAP_DEPTH)) u_map_ram (
        .i_clk  (i_clk),
        .i_we   (map_we),
        .i_waddr(r_map_cnt[MAW-1:0]),
        .i_wdata({i_entry_addr, i_entry_len, (i_entry_type == 32'd1)}),
        .i_raddr(r_ridx[MAW-1:0]),
        .o_rdata(map_rdata)
    );

    assign map_base   = map_rdata[2*AW:AW+1];
    assign map_len    = map_rdata[AW:1];
    assign map_usable = map_rdata[0];

    // Allocation history
    assign hist_we = (r_state == S_REC);

    ppfa_ram #(.WIDTH(AW), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (hist_we),
        .i_waddr(r_hist_cnt[HAW-1:0]),
        .i_wdata(r_p),
        .i_raddr(r_hidx[HAW-1:0]),
        .o_rdata(hist_rdata)
    );

    // Select the reserved range under test
    always_comb begin
        case (r_rng)
            2'd0:    begin rng_s = r_kstart; rng_e = r_kend; end
            2'd1:    begin rng_s = r_sstart; rng_e = r_send; end
            default: begin rng_s = {32'd0, r_bi_base}; rng_e = bi_end; end
        endcase
    end

    assign p_inc = ppfa_pkg::next_page(r_p);
    assign rnd_e = ppfa_pkg::round_page(rng_e);
    assign rnd_b = ppfa_pkg::round_page(map_base);

    // Steer operands into the shared unit
    always_comb begin
        alu_a = r_p;
        alu_b = r_end;
        unique case (r_state)
            S_CUR:   begin alu_a = r_cursor; alu_b = r_limit; end
            S_HIT1:  begin alu_a = r_p;      alu_b = rng_e;   end
            S_HIT2:  begin alu_a = rng_s;    alu_b = p_inc;   end
            S_RCHK:  begin alu_a = map_base; alu_b = map_len; end
            default: begin alu_a = r_p;      alu_b = r_end;   end
        endcase
    end

    ppfa_alu u_alu (
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_res(alu_res)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_map_cnt    <= '0;
            r_hist_cnt   <= '0;
            r_ridx       <= '0;
            r_hidx       <= '0;
            r_rng        <= '0;
            r_mode       <= 1'b0;
            r_cursor     <= '0;
            r_limit      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one loads now
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_page <= '0;
                        if (i_action == ppfa_pkg::ACT_LOAD) begin
                            if (map_we) begin
                                r_map_cnt    <= r_map_cnt + MCW'(1);
                                r_res_status <= ppfa_pkg::ST_OK;
                            end else begin
                                r_res_status <= ppfa_pkg::ST_MAP_FULL;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_ALLOC;
                        end
                    end
                end
                S_ALLOC: begin
                    if (r_hist_cnt >= HCW'(HISTORY_DEPTH)) begin
                        r_res_status <= ppfa_pkg::ST_HIST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_CUR;
                    end
                end
                S_CUR: begin
                    // continue the cursor if it is active and not exhausted
                    if (r_cursor != '0 && alu_res.lt) begin
                        r_p     <= r_cursor;
                        r_end   <= r_limit;
                        r_mode  <= 1'b0;
                        r_state <= S_FTOP;
                    end else begin
                        r_ridx  <= '0;
                        r_state <= S_RRD;
                    end
                end
                S_FTOP: begin
                    if (!alu_res.lt) begin
                        // no page left in this range
                        if (!r_mode) begin
                            r_cursor <= r_limit;
                            r_ridx   <= '0;
                        end else begin
                            r_ridx <= r_ridx + MCW'(1);
                        end
                        r_state <= S_RRD;
                    end else if (r_p[AW-1:20] == '0) begin
                        r_p <= ppfa_pkg::LOW_MEM_END;
                    end else begin
                        r_rng   <= 2'd0;
                        r_state <= S_HIT1;
                    end
                end
                S_HIT1, S_HIT2: begin
                    if (alu_res.lt && r_state == S_HIT1) begin
                        r_state <= S_HIT2;
                    end else if (alu_res.lt) begin
                        // page overlaps the range: jump past its end
                        if (rnd_e.ovf) begin
                            r_end   <= r_p;
                            r_state <= S_FTOP;
                        end else begin
                            r_p     <= rnd_e.val;
                            r_state <= S_FTOP;
                        end
                    end else if (r_rng == 2'd2) begin
                        r_hidx  <= '0;
                        r_state <= S_HRD;
                    end else begin
                        r_rng   <= r_rng + 2'd1;
                        r_state <= S_HIT1;
                    end
                end
                S_HRD: begin
                    if (r_hidx == r_hist_cnt) begin
                        // page is free
                        r_cursor <= p_inc;
                        if (r_mode) begin
                            r_limit <= r_end;
                        end
                        r_state <= S_REC;
                    end else begin
                        r_state <= S_HCMP;
                    end
                end
                S_HCMP: begin
                    if (hist_rdata == r_p) begin
                        r_p     <= p_inc;
                        r_state <= S_FTOP;
                    end else begin
                        r_hidx  <= r_hidx + HCW'(1);
                        r_state <= S_HRD;
                    end
                end
                S_RRD: begin
                    if (r_ridx >= r_map_cnt) begin
                        r_res_status <= ppfa_pkg::ST_NO_PAGE;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_RCHK;
                    end
                end
                S_RCHK: begin
                    // usable, no wrap, base can be page aligned
                    if (map_usable && !alu_res.sum[AW] && !rnd_b.ovf) begin
                        r_p     <= rnd_b.val;
                        r_end   <= {alu_res.sum[AW-1:PS], {PS{1'b0}}};
                        r_mode  <= 1'b1;
                        r_state <= S_FTOP;
                    end else begin
                        r_ridx  <= r_ridx + MCW'(1);
                        r_state <= S_RRD;
                    end
                end
                S_REC: begin
                    r_hist_cnt   <= r_hist_cnt + HCW'(1);
                    r_res_page   <= r_p;
                    r_res_status <= ppfa_pkg::ST_OK;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
            r_out_page   <= r_res_page;
            r_out_status <= r_res_status;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_page_addr = r_out_page;
    assign o_status    = r_out_status;

endmodule

// ===== rtl/ppfa_chk.sv =====
// ----------------------------------------------------------------------------
// ppfa_chk
// Port-level checks of the physical page frame allocator.
// ----------------------------------------------------------------------------
module ppfa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_page_addr,
    input logic [1:0]  o_status
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_page_addr) && $stable(o_status))
        else $error("result changed while stalled");

    // Failed items carry no page
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ppfa_pkg::ST_OK |-> o_page_addr == 64'd0)
        else $error("failed item carries a page");

    // Granted pages are aligned and above low memory
    a_page_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ppfa_pkg::ST_OK && o_page_addr != 64'd0
            |-> o_page_addr[11:0] == 12'd0 && o_page_addr[63:20] != 44'd0)
        else $error("bad page granted");

    // One item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("item accepted while busy");

endmodule

bind physical_page_frame_allocator_top ppfa_chk u_ppfa_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_page_addr(o_page_addr),
    .o_status   (o_status)
);
